// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, included by the core rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising edge outside reset
`define CSL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define CSL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define CSL_ASSERT(lbl, clk, rst_n, prop)
`define CSL_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/csl_pkg.sv -----
// ----------------------------------------------------------------------------
// csl_pkg
// constants and types of the set-associative tag directory
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int unsigned MaxWays    = 8;
  localparam int unsigned MaxSets    = 256;
  localparam int unsigned AgeBits    = 8;
  localparam int unsigned TagBits    = 32;
  localparam int unsigned Depth      = MaxSets * MaxWays;
  localparam int unsigned BlkBits    = $clog2(Depth);
  // one memory row holds the largest set the way register can select
  localparam int unsigned LaneBits   = 3;
  localparam int unsigned Lanes      = 1 << LaneBits;
  localparam int unsigned RowBits    = BlkBits - LaneBits;
  localparam int unsigned Rows       = 1 << RowBits;

  // configuration register indexes
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] CFG_WAY_BITS    = 2'd2;

  // request opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [TagBits-1:0] tag;
    logic [AgeBits-1:0] age;
  } entry_t;

  typedef entry_t [Lanes-1:0] row_t;

  typedef struct packed {
    logic                en;
    logic [RowBits-1:0]  row;
    logic [LaneBits-1:0] lane;
    entry_t              entry;
  } wr_req_t;

endpackage

// ----- rtl/cache_set_lookup_lru_victim_core.sv -----
// ----------------------------------------------------------------------------
// cache_set_lookup_lru_victim_core
// write: next transfer can follow at once, no result
// lookup: one memory row is read into a register, the lane compare stage works on
//   it and its result is loaded into the output register; a held result stalls
//   the compare stage, and no new request is taken until it hands over
// reset: config back to defaults, all rows flagged empty (no clearing pass)
// ----------------------------------------------------------------------------
module cache_set_lookup_lru_victim_core
  import csl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [3:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // address[31:0], way[34:32], valid_in[35],
                                        // age_in[43:36], zero fill
  input  logic        s_axis_tuser_i,   // op
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // block_number[10:0], age_out[18:11], zero fill
  output logic        m_axis_tuser_o    // hit
);

`include "assert_macros.svh"

  // configuration registers
  logic [3:0] offset_bits_q;
  logic [3:0] index_bits_q;
  logic [1:0] way_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= 4'd2;
      index_bits_q  <= 4'd4;
      way_bits_q    <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i;
        CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata_i;
        CFG_WAY_BITS:    way_bits_q    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // request fields
  logic                in_op;
  logic [31:0]         in_addr;
  logic [2:0]          in_way;
  logic                in_valid;
  logic [AgeBits-1:0]  in_age;

  assign in_op    = s_axis_tuser_i;
  assign in_addr  = s_axis_tdata_i[31:0];
  assign in_way   = s_axis_tdata_i[34:32];
  assign in_valid = s_axis_tdata_i[35];
  assign in_age   = s_axis_tdata_i[43:36];

  // address split: only the low block-number bits of the set index matter,
  // since the block number wraps at the directory depth
  logic [31:0]         addr_shr;
  logic [BlkBits-1:0]  set_lo;
  logic [BlkBits-1:0]  base_blk;
  logic [4:0]          tag_shift;
  logic [TagBits-1:0]  in_tag;
  logic [LaneBits-1:0] way_mask;
  logic [LaneBits-1:0] wr_lane;

  assign addr_shr  = in_addr >> offset_bits_q;
  assign set_lo    = addr_shr[BlkBits-1:0] & ~({BlkBits{1'b1}} << index_bits_q);
  // sets are aligned to their way count, so a set never straddles two rows
  assign base_blk  = set_lo << way_bits_q;
  assign tag_shift = 5'(offset_bits_q) + 5'(index_bits_q);
  assign in_tag    = in_addr >> tag_shift;
  assign way_mask  = ~({LaneBits{1'b1}} << way_bits_q);
  assign wr_lane   = base_blk[LaneBits-1:0] | (in_way & way_mask);

  // handshake and lookup stage
  logic in_xfer;
  logic out_free;
  logic busy_q;
  logic done;

  logic [TagBits-1:0]  lk_tag_q;
  logic [BlkBits-1:0]  lk_base_q;
  logic [1:0]          lk_wb_q;

  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = ~busy_q;
  assign out_free        = ~m_axis_tvalid_o | m_axis_tready_i;
  // compare stage hands over only when the output register can take it
  assign done            = busy_q & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_xfer && in_op == OP_LOOKUP) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_op == OP_LOOKUP) begin
      lk_tag_q  <= in_tag;
      lk_base_q <= base_blk;
      lk_wb_q   <= way_bits_q;
    end
  end

  // directory memory
  wr_req_t wr_req;
  row_t    rd_row;
  logic    rd_ok;

  assign wr_req.en          = in_xfer & (in_op == OP_WRITE);
  assign wr_req.row         = base_blk[BlkBits-1:LaneBits];
  assign wr_req.lane        = wr_lane;
  assign wr_req.entry.valid = in_valid;
  assign wr_req.entry.tag   = in_tag;
  assign wr_req.entry.age   = in_age;

  csl_dir_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_req),
    .rd_en_i   (in_xfer & (in_op == OP_LOOKUP)),
    .rd_row_i  (base_blk[BlkBits-1:LaneBits]),
    .rd_data_o (rd_row),
    .rd_ok_o   (rd_ok)
  );

  // lane compare: first valid tag match wins, else the oldest way,
  // ties to the lowest way
  logic                hit_c;
  logic [LaneBits-1:0] hit_lane;
  logic [LaneBits-1:0] best_lane;
  logic [AgeBits-1:0]  best_age;
  logic [AgeBits-1:0]  hit_age;
  logic [LaneBits-1:0] ln;
  logic                ln_vld;
  logic [AgeBits-1:0]  ln_age;
  logic [LaneBits:0]   n_ways;

  always_comb begin
    n_ways    = (LaneBits+1)'(1) << lk_wb_q;
    hit_c     = 1'b0;
    hit_lane  = lk_base_q[LaneBits-1:0];
    hit_age   = '0;
    best_lane = lk_base_q[LaneBits-1:0];
    best_age  = rd_ok ? rd_row[lk_base_q[LaneBits-1:0]].age : '0;
    ln        = '0;
    ln_vld    = 1'b0;
    ln_age    = '0;
    for (int w = 0; w < Lanes; w++) begin
      if ((LaneBits+1)'(w) < n_ways) begin
        ln     = lk_base_q[LaneBits-1:0] | LaneBits'(w);
        ln_vld = rd_ok & rd_row[ln].valid;
        ln_age = rd_ok ? rd_row[ln].age : '0;
        if (!hit_c && ln_vld && rd_row[ln].tag == lk_tag_q) begin
          hit_c    = 1'b1;
          hit_lane = ln;
          hit_age  = ln_age;
        end
        if (ln_age > best_age) begin
          best_age  = ln_age;
          best_lane = ln;
        end
      end
    end
  end

  // output register
  logic                out_vld_q;
  logic                out_hit_q;
  logic [BlkBits-1:0]  out_blk_q;
  logic [AgeBits-1:0]  out_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_hit_q <= hit_c;
      out_blk_q <= {lk_base_q[BlkBits-1:LaneBits], hit_c ? hit_lane : best_lane};
      out_age_q <= hit_c ? hit_age : best_age;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_hit_q;
  assign m_axis_tdata_o  = {5'd0, out_age_q, out_blk_q};

  // a lookup transfer always opens the compare stage
  `CSL_ASSERT(a_lookup_busy, clk_i, rst_ni,
              (in_xfer && in_op == OP_LOOKUP) |=> busy_q)
  // a result only appears after a compare stage
  `CSL_ASSERT(a_result_src, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(busy_q))
  // with a free output the compare stage closes in the following cycle
  `CSL_ASSERT(a_busy_one, clk_i, rst_ni, (busy_q && !m_axis_tvalid_o) |=> !busy_q)
  // no memory write while a lookup is reading its row
  `CSL_ASSERT_NEVER(a_no_wr_busy, clk_i, rst_ni, busy_q && wr_req.en)

endmodule

// ----- rtl/csl_dir_mem.sv -----
// ----------------------------------------------------------------------------
// csl_dir_mem
// directory memory, one row of lanes per word, with per-row valid flags
// ----------------------------------------------------------------------------
module csl_dir_mem
  import csl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wr_req_t            wr_i,
  input  logic               rd_en_i,
  input  logic [RowBits-1:0] rd_row_i,
  output row_t               rd_data_o,
  output logic               rd_ok_o
);

  row_t              mem [Rows];
  logic [Rows-1:0]   row_vld_q;
  row_t              fill_row;
  row_t              rd_data_q;
  logic              rd_ok_q;

  // a row never written reads as all invalid, age zero: first write clears it
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      fill_row[l] = (LaneBits'(l) == wr_i.lane) ? wr_i.entry : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (row_vld_q[wr_i.row]) begin
        mem[wr_i.row][wr_i.lane] <= wr_i.entry;
      end else begin
        mem[wr_i.row] <= fill_row;
      end
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_vld_q[wr_i.row] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= row_vld_q[rd_row_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_ok_o   = rd_ok_q;

endmodule

// ----- bench/cache_set_lookup_lru_victim_core_test.sv -----
// ----------------------------------------------------------------------------
// cache_set_lookup_lru_victim_core_test
// self-checking bench for the set-associative tag directory: a directed pass
// over hits, misses, victim ties and masked ways, then random write/lookup
// traffic under several address splits, each lookup result checked against
// an in-bench model of the directory contents
// ----------------------------------------------------------------------------
module cache_set_lookup_lru_victim_core_test
  import csl_pkg::*;
();

  // one request transfer as the sender sees it
  typedef struct {
    logic        op;
    logic [31:0] address;
    logic [2:0]  way;
    logic        valid;
    logic [7:0]  age;
  } dir_request_t;

  // one lookup answer
  typedef struct {
    logic        hit;
    logic [10:0] block;
    logic [7:0]  age;
  } lookup_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;   // address[31:0], way[34:32], valid_in[35], age_in[43:36]
  logic        s_axis_tuser_i;   // op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;   // block_number[10:0], age_out[18:11]
  logic        m_axis_tuser_o;   // hit

  // model of the directory: one entry per block, plus the split in force
  logic              dir_valid [Depth];
  logic [TagBits-1:0] dir_tag  [Depth];
  logic [AgeBits-1:0] dir_age  [Depth];
  int unsigned       split_offset;
  int unsigned       split_index;
  int unsigned       split_way;

  // answers owed by the block, oldest first
  lookup_result_t    owed_lookups [$];
  int unsigned       mismatch_count;

  // idling odds in percent, changed between phases
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;

  cache_set_lookup_lru_victim_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // generous ceiling, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("cache_set_lookup_lru_victim_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // directory model
  // ---------------------------------------------------------------------------

  // block number of a way within a set, wrapping at the store depth
  function automatic int unsigned block_of(input int unsigned set_idx, input int unsigned w);
    return ((set_idx << split_way) + w) % Depth;
  endfunction

  // builds an address from tag, set and byte offset under the current split
  function automatic logic [31:0] make_address(input logic [31:0] tag, input int unsigned set_idx,
                                               input logic [31:0] byte_ofs);
    logic [31:0] a;
    a = (tag << (split_offset + split_index))
      | ((set_idx & ((32'd1 << split_index) - 1)) << split_offset)
      | (byte_ofs & ((32'd1 << split_offset) - 1));
    return a;
  endfunction

  // first valid matching way wins; otherwise the oldest way, lowest on a tie
  function automatic lookup_result_t probe_directory(input logic [31:0] address);
    lookup_result_t res;
    int unsigned    set_idx;
    int unsigned    blk;
    int unsigned    w;
    logic [31:0]    tag;
    logic           found;
    set_idx   = (address >> split_offset) & ((32'd1 << split_index) - 1);
    tag       = address >> (split_offset + split_index);
    blk       = block_of(set_idx, 0);
    res.hit   = 1'b0;
    res.block = blk[10:0];
    res.age   = dir_age[blk];
    found     = 1'b0;
    for (w = 0; w < (32'd1 << split_way); w++) begin
      blk = block_of(set_idx, w);
      if (!found) begin
        if (dir_valid[blk] && dir_tag[blk] == tag) begin
          found     = 1'b1;
          res.hit   = 1'b1;
          res.block = blk[10:0];
          res.age   = dir_age[blk];
        end else if (dir_age[blk] > res.age) begin
          res.block = blk[10:0];
          res.age   = dir_age[blk];
        end
      end
    end
    return res;
  endfunction

  // applies one accepted request to the model, queueing the answer of a lookup
  function automatic void apply_request(input dir_request_t rq);
    int unsigned set_idx;
    int unsigned blk;
    if (rq.op == OP_LOOKUP) begin
      owed_lookups.push_back(probe_directory(rq.address));
    end else begin
      set_idx        = (rq.address >> split_offset) & ((32'd1 << split_index) - 1);
      // out-of-range way numbers fold back into the set
      blk            = block_of(set_idx, 32'(rq.way) & ((32'd1 << split_way) - 1));
      dir_valid[blk] = rq.valid;
      dir_tag[blk]   = rq.address >> (split_offset + split_index);
      dir_age[blk]   = rq.age;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d: %s expected 0x%0h got 0x%0h", mismatch_count, what, want, got);
    end
  endtask

  // result transfers are taken at the rising edge, fields compared one by one
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (owed_lookups.size() == 0) begin
        log_mismatch("result with nothing owed, block", 32'd0, 32'(m_axis_tdata_o[10:0]));
      end else begin
        want = owed_lookups.pop_front();
        if (want.hit !== m_axis_tuser_o) begin
          log_mismatch("hit", 32'(want.hit), 32'(m_axis_tuser_o));
        end
        if (want.block !== m_axis_tdata_o[10:0]) begin
          log_mismatch("block_number", 32'(want.block), 32'(m_axis_tdata_o[10:0]));
        end
        if (want.age !== m_axis_tdata_o[18:11]) begin
          log_mismatch("age_out", 32'(want.age), 32'(m_axis_tdata_o[18:11]));
        end
      end
    end
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // presents one request and holds it until the transfer happens
  task automatic send_request(input dir_request_t rq);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= rq.op;
    s_axis_tdata_i  <= {4'b0, rq.age, rq.valid, rq.way, rq.address};
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    apply_request(rq);
  endtask

  task automatic send_write(input logic [31:0] address, input logic [2:0] way,
                            input logic valid, input logic [7:0] age);
    dir_request_t rq;
    rq = '{op: OP_WRITE, address: address, way: way, valid: valid, age: age};
    send_request(rq);
  endtask

  task automatic send_lookup(input logic [31:0] address);
    dir_request_t rq;
    rq = '{op: OP_LOOKUP, address: address, way: 3'($urandom()), valid: 1'($urandom()),
           age: 8'($urandom())};
    send_request(rq);
  endtask

  // stops sending and waits for every owed answer, then lets a trailing
  // write (which has no answer) finish inside the block
  task automatic wait_directory_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (owed_lookups.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [3:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_OFFSET_BITS: split_offset = 32'(value);
      CFG_INDEX_BITS:  split_index  = 32'(value);
      CFG_WAY_BITS:    split_way    = 32'(value[1:0]);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset split: 4-byte blocks, 16 sets, 2 ways
  task automatic test_directed_lookups();
    // empty directory: all ages zero, so the victim is way 0
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
    // same tag in both ways of set 3: the lower way must win
    send_write(make_address(32'h155, 3, 0), 3'd0, 1'b1, 8'd0);
    send_write(make_address(32'h155, 3, 1), 3'd1, 1'b1, 8'd255);
    send_lookup(make_address(32'h155, 3, 2));
    // matching tag but cleared valid bit must not hit: way 1 still matches
    send_write(make_address(32'h155, 3, 0), 3'd0, 1'b0, 8'd7);
    send_lookup(make_address(32'h155, 3, 3));
    // way 5 folds onto way 1; then a miss picks the older way
    send_write(make_address(32'h2AA, 3, 0), 3'd5, 1'b1, 8'd9);
    send_lookup(make_address(32'h155, 3, 0));
    // equal ages: the victim is the lowest way
    send_write(make_address(32'h2AA, 3, 0), 3'd1, 1'b0, 8'd7);
    send_lookup(make_address(32'h155, 3, 0));
    // top of the address space, way 7 folding onto way 1
    send_write(32'hFFFF_FFFF, 3'd7, 1'b1, 8'd255);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFC);
    // bottom of the address space, then a tag miss in the same set
    send_write(32'h0000_0000, 3'd0, 1'b1, 8'd0);
    send_lookup(32'h0000_0003);
    send_lookup(32'h0000_0040);
  endtask

  // random traffic under one split: hot tags and sets make hits and
  // evictions common, a few fully random addresses keep every bit moving
  task automatic test_random_traffic(input logic [3:0] offset_bits, input logic [3:0] index_bits,
                                     input logic [1:0] way_bits, input int unsigned n_items);
    logic [31:0]  hot_tags [4];
    logic [31:0]  tag;
    logic [31:0]  addr;
    int unsigned  set_idx;
    int unsigned  i;
    dir_request_t rq;
    wait_directory_idle();
    write_register(CFG_OFFSET_BITS, offset_bits);
    write_register(CFG_INDEX_BITS, index_bits);
    write_register(CFG_WAY_BITS, {2'b0, way_bits});
    for (i = 0; i < 4; i++) begin
      hot_tags[i] = $urandom();
    end
    for (i = 0; i < n_items; i++) begin
      // sender holds off until the block has answered everything
      if (i % 150 == 75) begin
        wait_directory_idle();
      end
      tag     = ($urandom_range(99) < 85) ? hot_tags[$urandom_range(3)] : $urandom();
      set_idx = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom();
      addr    = make_address(tag, set_idx, $urandom());
      if ($urandom_range(99) < 5) begin
        addr = $urandom();
      end
      rq.op      = ($urandom_range(99) < 45) ? OP_WRITE : OP_LOOKUP;
      rq.address = addr;
      rq.way     = 3'($urandom_range(7));
      rq.valid   = ($urandom_range(99) < 80);
      // small ages now and then, so victim ties turn up
      rq.age     = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      send_request(rq);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned b;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_OFFSET_BITS;
    cfg_wdata_i     = 4'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_WRITE;
    m_axis_tready_i = 1'b0;
    send_idle_pct   = 11;
    recv_idle_pct   = 88;
    mismatch_count  = 0;
    split_offset    = 2;
    split_index     = 4;
    split_way       = 1;
    for (b = 0; b < Depth; b++) begin
      dir_valid[b] = 1'b0;
      dir_tag[b]   = '0;
      dir_age[b]   = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // slow receiver
    test_directed_lookups();
    test_random_traffic(4'd2, 4'd4, 2'd1, 310);
    test_random_traffic(4'd0, 4'd0, 2'd0, 310);

    // slow sender
    send_idle_pct = 88;
    recv_idle_pct = 11;
    test_random_traffic(4'd12, 4'd8, 2'd3, 310);
    test_random_traffic(4'd5, 4'd3, 2'd2, 310);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(4'd0, 4'd8, 2'd3, 310);
    test_random_traffic(4'd12, 4'd0, 2'd2, 310);

    wait_directory_idle();
    repeat (8) @(posedge clk_i);
    if (owed_lookups.size() != 0) begin
      log_mismatch("answers never delivered, count", 32'd0, 32'(owed_lookups.size()));
    end
    if (mismatch_count == 0) begin
      $display("cache_set_lookup_lru_victim_core verification clean");
    end else begin
      $display("cache_set_lookup_lru_victim_core verification failed");
    end
    $finish;
  end

endmodule

// ----- cache_set_lookup_lru_victim_core.f -----
+incdir+rtl
rtl/csl_pkg.sv
rtl/csl_dir_mem.sv
rtl/cache_set_lookup_lru_victim_core.sv
bench/cache_set_lookup_lru_victim_core_test.sv
